/* rtl/core/ecal_pkg.sv */
// Shared types, constants and a helper function for the epoch-to-calendar block.
package ecal_pkg;

  // Field widths.
  localparam int unsigned SecsW   = 32;
  localparam int unsigned PrescW  = 20;
  localparam int unsigned DivW    = 21;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned DsecW   = 17;
  localparam int unsigned AddrW   = 3;

  // Constant divisors and scale factors.
  localparam logic [DivW-1:0] SECS_PER_DAY  = 21'd86400;
  localparam logic [DivW-1:0] SECS_PER_HOUR = 21'd3600;
  localparam logic [DivW-1:0] SECS_PER_MIN  = 21'd60;
  localparam logic [DivW-1:0] DAYS_PER_WEEK = 21'd7;
  localparam logic [9:0]      MS_PER_SEC    = 10'd1000;
  localparam logic [11:0]     EPOCH_YEAR    = 12'd1970;
  localparam logic [31:0]     EPOCH_WDAY    = 32'd3;
  localparam logic [8:0]      DAYS_LEAP     = 9'd366;
  localparam logic [8:0]      DAYS_COMMON   = 9'd365;

  // Rounded-up reciprocals for the constant divisions. The power of two in the
  // divisor is shifted off first, so each one only has to cover the odd part:
  // day 2^35/675 on secs>>7, week 2^19/7, hour 2^21/225 on dsec>>4,
  // minute 2^14/15 on dsec>>2. Each is exact over its operand range.
  localparam logic [25:0] RCP_DAY  = 26'd50903317;
  localparam logic [16:0] RCP_WEEK = 17'd74899;
  localparam logic [13:0] RCP_HOUR = 14'd9321;
  localparam logic [10:0] RCP_MIN  = 11'd1093;

  // Phase of the epoch year in the leap-rule cycles.
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;
  localparam logic [6:0] LAST_MOD100  = 7'd99;
  localparam logic [8:0] LAST_MOD400  = 9'd399;
  localparam logic [3:0] LAST_MONTH   = 4'd11;

  // Register map.
  localparam logic [AddrW-1:0] ADDR_PRESC  = 3'd0;
  localparam logic [PrescW-1:0] PRESC_RESET = 20'd32767;

  // Division jobs, in this order.
  localparam logic [2:0] OP_DAY  = 3'd0;
  localparam logic [2:0] OP_WDAY = 3'd1;
  localparam logic [2:0] OP_HOUR = 3'd2;
  localparam logic [2:0] OP_MIN  = 3'd3;
  localparam logic [2:0] OP_MS   = 3'd4;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_cap;
    logic [2:0] op;
    logic       ms_zero;
    logic       year_step;
    logic       mon_step;
    logic       out_load;
  } ecal_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic ms_ok;
    logic year_fits;
    logic mon_last;
    logic out_free;
  } ecal_sts_t;

  // One result word.
  typedef struct packed {
    logic [11:0] year_value;
    logic [3:0]  month_value;
    logic [4:0]  day_value;
    logic [2:0]  weekday_value;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [5:0]  second_value;
    logic [9:0]  millisecond_value;
  } ecal_out_t;

  // Length of month m (0 is January), with February stretched in leap years.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1:                      n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/ecal_in_if.sv */
// Input channel: seconds count and sub-second divider with valid/ready.
interface ecal_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] counter_seconds;
  logic [19:0] divider_value;

  modport source (output valid, output counter_seconds, output divider_value, input ready);
  modport sink   (input valid, input counter_seconds, input divider_value, output ready);
endinterface

/* rtl/core/ecal_out_if.sv */
// Result channel: calendar date and time with valid/ready.
interface ecal_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year_value;
  logic [3:0]  month_value;
  logic [4:0]  day_value;
  logic [2:0]  weekday_value;
  logic [4:0]  hour_value;
  logic [5:0]  minute_value;
  logic [5:0]  second_value;
  logic [9:0]  millisecond_value;

  modport source (output valid, output year_value, output month_value, output day_value,
                  output weekday_value, output hour_value, output minute_value,
                  output second_value, output millisecond_value, input ready);
  modport sink   (input valid, input year_value, input month_value, input day_value,
                  input weekday_value, input hour_value, input minute_value,
                  input second_value, input millisecond_value, output ready);
endinterface

/* rtl/core/ecal_div.sv */
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
module ecal_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [20:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [20:0] remainder
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [20:0] rem_r, rem_nxt;
  logic [20:0] dsr_r, dsr_nxt;
  logic [21:0] shifted;
  logic [21:0] trial;
  logic        fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_r, quo_r[31]};
  assign trial   = shifted - {1'b0, dsr_r};
  assign fits    = shifted >= {1'b0, dsr_r};

  // Next-state logic for one step.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], fits};
      rem_nxt = fits ? trial[20:0] : shifted[20:0];
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flops.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/core/ecal_dp.sv */
// Datapath: operand registers, divider, year and month stepping, result register.
module ecal_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ecal_pkg::ecal_cmd_t  cmd,
  output ecal_pkg::ecal_sts_t  sts,
  input  logic [19:0]          presc,
  input  logic [31:0]          in_secs,
  input  logic [19:0]          in_div,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ecal_pkg::ecal_out_t  out_word
);

  logic [31:0] secs_r;
  logic [29:0] prod_r;
  logic        ms_ok_r;
  logic [15:0] days_r;
  logic [16:0] dsec_r;
  logic [2:0]  wday_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [9:0]  ms_r;
  logic [11:0] year_r;
  logic [3:0]  mon_r;
  logic [1:0]  y4_r;
  logic [6:0]  y100_r;
  logic [8:0]  y400_r;
  logic        out_valid_r;
  ecal_pkg::ecal_out_t out_r;
  logic        cbusy_r;
  logic        cdone_r;
  logic [15:0] cq_r;
  logic [31:0] cn_r;
  logic [20:0] crem_r;

  logic [19:0] frac;
  logic [29:0] prod;
  logic [31:0] dvd;
  logic [20:0] dsr;
  logic        div_done;
  logic [31:0] quo;
  logic [20:0] rem;
  logic        m_start;
  logic        m_done;
  logic [31:0] m_quo;
  logic [20:0] m_rem;
  logic        c_start;
  logic [50:0] day_prod;
  logic [32:0] wday_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [15:0] c_quo;
  logic [36:0] c_back;
  logic [31:0] c_diff;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        out_free;

  // Ticks left in the second, scaled to milliseconds before the divide.
  assign frac = presc - in_div;
  assign prod = frac * ecal_pkg::MS_PER_SEC;

  // Operand selection for the current division job.
  always_comb begin
    case (cmd.op)
      ecal_pkg::OP_DAY: begin
        dvd = secs_r;
        dsr = ecal_pkg::SECS_PER_DAY;
      end
      ecal_pkg::OP_WDAY: begin
        dvd = {16'd0, days_r} + ecal_pkg::EPOCH_WDAY;
        dsr = ecal_pkg::DAYS_PER_WEEK;
      end
      ecal_pkg::OP_HOUR: begin
        dvd = {15'd0, dsec_r};
        dsr = ecal_pkg::SECS_PER_HOUR;
      end
      ecal_pkg::OP_MIN: begin
        dvd = {15'd0, dsec_r};
        dsr = ecal_pkg::SECS_PER_MIN;
      end
      ecal_pkg::OP_MS: begin
        dvd = {2'd0, prod_r};
        dsr = {1'b0, presc} + 21'd1;
      end
      default: begin
        dvd = secs_r;
        dsr = ecal_pkg::SECS_PER_DAY;
      end
    endcase
  end

  // The millisecond divisor varies with the prescaler, so it uses the shift-subtract divider.
  assign m_start = cmd.div_start && (cmd.op == ecal_pkg::OP_MS);
  assign c_start = cmd.div_start && (cmd.op != ecal_pkg::OP_MS);

  ecal_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (m_start),
    .dividend  (dvd),
    .divisor   (dsr),
    .done      (m_done),
    .quotient  (m_quo),
    .remainder (m_rem)
  );

  // Constant divisions: quotient by reciprocal multiplication in the start cycle.
  assign day_prod  = {26'd0, dvd[31:7]} * {25'd0, ecal_pkg::RCP_DAY};
  assign wday_prod = {17'd0, dvd[15:0]} * {16'd0, ecal_pkg::RCP_WEEK};
  assign hour_prod = {14'd0, dvd[16:4]} * {13'd0, ecal_pkg::RCP_HOUR};
  assign min_prod  = {11'd0, dvd[11:2]} * {10'd0, ecal_pkg::RCP_MIN};

  always_comb begin
    case (cmd.op)
      ecal_pkg::OP_WDAY: c_quo = {2'd0, wday_prod[32:19]};
      ecal_pkg::OP_HOUR: c_quo = {10'd0, hour_prod[26:21]};
      ecal_pkg::OP_MIN:  c_quo = {9'd0, min_prod[20:14]};
      default:           c_quo = day_prod[50:35];
    endcase
  end

  // The remainder follows in the next cycle by multiplying back and subtracting.
  assign c_back = {21'd0, cq_r} * {16'd0, dsr};
  assign c_diff = cn_r - c_back[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbusy_r <= 1'b0;
      cdone_r <= 1'b0;
    end else begin
      cbusy_r <= c_start;
      cdone_r <= cbusy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_start) begin
      cq_r <= c_quo;
      cn_r <= dvd;
    end
    if (cbusy_r) begin
      crem_r <= c_diff[20:0];
    end
  end

  // Division results for the current job.
  assign div_done = (cmd.op == ecal_pkg::OP_MS) ? m_done : cdone_r;
  assign quo      = (cmd.op == ecal_pkg::OP_MS) ? m_quo : {16'd0, cq_r};
  assign rem      = (cmd.op == ecal_pkg::OP_MS) ? m_rem : crem_r;

  // Gregorian leap rule from the year's phase counters.
  assign leap = (y4_r == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
  assign ylen = leap ? ecal_pkg::DAYS_LEAP : ecal_pkg::DAYS_COMMON;
  assign mlen = ecal_pkg::month_len(mon_r, leap);

  assign out_free = !out_valid_r || out_ready;

  // Status back to the controller.
  always_comb begin
    sts.div_done  = div_done;
    sts.ms_ok     = ms_ok_r;
    sts.year_fits = days_r < {7'd0, ylen};
    sts.mon_last  = (mon_r == ecal_pkg::LAST_MONTH) || (days_r < {11'd0, mlen});
    sts.out_free  = out_free;
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs_r  <= in_secs;
      prod_r  <= prod;
      ms_ok_r <= (presc != 20'd0) && (in_div <= presc);
      year_r  <= ecal_pkg::EPOCH_YEAR;
      mon_r   <= '0;
      y4_r    <= ecal_pkg::EPOCH_MOD4;
      y100_r  <= ecal_pkg::EPOCH_MOD100;
      y400_r  <= ecal_pkg::EPOCH_MOD400;
    end
    if (cmd.div_cap) begin
      case (cmd.op)
        ecal_pkg::OP_DAY: begin
          days_r <= quo[15:0];
          dsec_r <= rem[16:0];
        end
        ecal_pkg::OP_WDAY: wday_r <= rem[2:0] + 3'd1;
        ecal_pkg::OP_HOUR: begin
          hour_r <= quo[4:0];
          dsec_r <= rem[16:0];
        end
        ecal_pkg::OP_MIN: begin
          min_r <= quo[5:0];
          sec_r <= rem[5:0];
        end
        ecal_pkg::OP_MS: ms_r <= quo[9:0];
        default: ms_r <= ms_r;
      endcase
    end
    if (cmd.ms_zero) begin
      ms_r <= '0;
    end
    // Take off one whole year and advance the leap phase counters.
    if (cmd.year_step) begin
      days_r <= days_r - {7'd0, ylen};
      year_r <= year_r + 12'd1;
      y4_r   <= y4_r + 2'd1;
      y100_r <= (y100_r == ecal_pkg::LAST_MOD100) ? 7'd0 : y100_r + 7'd1;
      y400_r <= (y400_r == ecal_pkg::LAST_MOD400) ? 9'd0 : y400_r + 9'd1;
    end
    // Take off one whole month.
    if (cmd.mon_step) begin
      days_r <= days_r - {11'd0, mlen};
      mon_r  <= mon_r + 4'd1;
    end
    if (cmd.out_load) begin
      out_r.year_value        <= year_r;
      out_r.month_value       <= mon_r + 4'd1;
      out_r.day_value         <= days_r[4:0] + 5'd1;
      out_r.weekday_value     <= wday_r;
      out_r.hour_value        <= hour_r;
      out_r.minute_value      <= min_r;
      out_r.second_value      <= sec_r;
      out_r.millisecond_value <= ms_r;
    end
  end

  // Result word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

/* rtl/core/ecal_ctrl.sv */
// Controller: sequences the divisions, the year and month loops and the result load.
module ecal_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ecal_pkg::ecal_sts_t sts,
  output ecal_pkg::ecal_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_GO    = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_YEAR  = 3'd3;
  localparam logic [2:0] ST_MONTH = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cmd           = '0;
    cmd.op        = op_r;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = ecal_pkg::OP_DAY;
          state_nxt = ST_GO;
        end
      end
      ST_GO: begin
        if ((op_r == ecal_pkg::OP_MS) && !sts.ms_ok) begin
          cmd.ms_zero = 1'b1;
          state_nxt   = ST_YEAR;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          if (op_r == ecal_pkg::OP_MS) begin
            state_nxt = ST_YEAR;
          end else begin
            op_nxt    = op_r + 3'd1;
            state_nxt = ST_GO;
          end
        end
      end
      ST_YEAR: begin
        if (sts.year_fits) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts.mon_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mon_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State flops.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= ecal_pkg::OP_DAY;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

/* rtl/core/epoch_seconds_to_calendar_unit.sv */
// Top level: epoch seconds to calendar date and time, with prescaler register.
//
//   Channel   Direction  Handshake        Word
//   in_ch     sink       valid/ready      counter_seconds, divider_value
//   out_ch    source     valid/ready      year .. millisecond
//   APB       slave      psel/penable     prescaler_value at byte address 0
//
// One word is converted at a time. The day, weekday, hour and minute divisions use
// reciprocal multiplication; the millisecond division runs on the 32-step
// shift-subtract divider, or is skipped when the field is forced to zero. Then the
// year loop takes off one whole year past 1970 per step (up to 136), the month loop
// one whole month per step (up to 11), and the result is loaded.
// Reset is synchronous and active low; the prescaler returns to 32767.
// A finished word waits in the output register; the next input word is accepted
// meanwhile, and its result is held back only until the output register is free.
module epoch_seconds_to_calendar_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  ecal_in_if.sink                     in_ch,
  ecal_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ecal_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [19:0]          presc_r;
  logic                 presc_wr;
  ecal_pkg::ecal_cmd_t  cmd;
  ecal_pkg::ecal_sts_t  sts;
  ecal_pkg::ecal_out_t  out_word;

  // Configuration register write and readback.
  assign pready   = 1'b1;
  assign presc_wr = psel && penable && pwrite && (paddr == ecal_pkg::ADDR_PRESC);
  assign prdata   = (paddr == ecal_pkg::ADDR_PRESC) ? {12'd0, presc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r <= ecal_pkg::PRESC_RESET;
    end else if (presc_wr) begin
      presc_r <= pwdata[19:0];
    end
  end

  ecal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ecal_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .presc     (presc_r),
    .in_secs   (in_ch.counter_seconds),
    .in_div    (in_ch.divider_value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  // Result fields onto the output channel.
  assign out_ch.year_value        = out_word.year_value;
  assign out_ch.month_value       = out_word.month_value;
  assign out_ch.day_value         = out_word.day_value;
  assign out_ch.weekday_value     = out_word.weekday_value;
  assign out_ch.hour_value        = out_word.hour_value;
  assign out_ch.minute_value      = out_word.minute_value;
  assign out_ch.second_value      = out_word.second_value;
  assign out_ch.millisecond_value = out_word.millisecond_value;

endmodule

/* rtl/core/ecal_chk.sv */
// Port-level checker for the epoch-to-calendar block, bound to the top level.
module ecal_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] year_value,
  input logic [3:0]  month_value,
  input logic [4:0]  day_value,
  input logic [2:0]  weekday_value,
  input logic [4:0]  hour_value,
  input logic [5:0]  minute_value,
  input logic [5:0]  second_value,
  input logic [9:0]  millisecond_value
);

  // A stalled result word stays valid, and its year, month, day and millisecond fields stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(year_value) && $stable(month_value)
      && $stable(day_value) && $stable(millisecond_value))
    else $error("result word changed while stalled");

  // The block takes one word at a time, so it is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // Date fields lie within the calendar.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> year_value >= 12'd1970 && year_value <= 12'd2106
      && month_value >= 4'd1 && month_value <= 4'd12
      && day_value >= 5'd1 && weekday_value >= 3'd1)
    else $error("date field out of range");

  // Time-of-day fields lie within their units.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hour_value <= 5'd23 && minute_value <= 6'd59 && second_value <= 6'd59
      && millisecond_value <= 10'd999)
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_unit ecal_chk u_ecal_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .year_value        (out_ch.year_value),
  .month_value       (out_ch.month_value),
  .day_value         (out_ch.day_value),
  .weekday_value     (out_ch.weekday_value),
  .hour_value        (out_ch.hour_value),
  .minute_value      (out_ch.minute_value),
  .second_value      (out_ch.second_value),
  .millisecond_value (out_ch.millisecond_value)
);
